@@ design/ptms_pkg.sv @@
// Package for the periodic tick match scheduler.
// Holds payload structs, register indexes, reset values and the microcode ROM.
// No dependencies; every other design file uses it.
package ptms_pkg;

  // Default parameter values
  localparam int MAX_CATCHUP_DEF   = 64;
  localparam int COUNTER_WIDTH_DEF = 32;

  // Fixed field widths
  localparam int CNT_W = 7;
  localparam int ERR_W = 17;

  // Configuration register indexes
  localparam logic [2:0] REG_HARD_STEP       = 3'd0;
  localparam logic [2:0] REG_HARD_REMAINDER  = 3'd1;
  localparam logic [2:0] REG_TICKS_PER_SEC   = 3'd2;
  localparam logic [2:0] REG_STAT_STEP       = 3'd3;
  localparam logic [2:0] REG_GUARD_TICKS     = 3'd4;

  // Register reset values
  localparam logic [31:0] RST_HARD_STEP      = 32'd36864;
  localparam logic [15:0] RST_HARD_REMAINDER = 16'd0;
  localparam logic [15:0] RST_TICKS_PER_SEC  = 16'd100;
  localparam logic [31:0] RST_STAT_STEP      = 32'd57600;
  localparam logic [15:0] RST_GUARD_TICKS    = 16'd500;

  // Operation codes
  localparam logic [1:0] OP_HARD    = 2'd0;
  localparam logic [1:0] OP_STAT    = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] counter_now;
  } in_word_t;

  typedef struct packed {
    logic [31:0]      next_match;
    logic [CNT_W-1:0] tick_count;
    logic             catchup_overrun;
    logic             guard_applied;
  } out_word_t;

  // Datapath operations driven by one control word
  typedef enum logic [2:0] {
    DP_NOP,
    DP_CAPTURE,
    DP_LOAD,
    DP_STEP,
    DP_LOOP,
    DP_STORE,
    DP_GUARD,
    DP_OUTPUT
  } dp_op_t;

  // Jump conditions; restart is its own bit in the control word, not an op
  typedef enum logic [2:0] {
    COND_NONE,
    COND_ALWAYS,
    COND_NO_ITEM,
    COND_SPECIAL,
    COND_LOOP
  } cond_t;

  localparam int PC_W = 3;
  typedef logic [PC_W-1:0] pc_t;

  // Control word: datapath op, restart flag, jump condition, jump target, output slot needed
  typedef struct packed {
    dp_op_t op;
    logic   restart;
    cond_t  cond;
    pc_t    target;
    logic   need_out;
  } ucode_t;

  // Program addresses
  localparam pc_t UA_WAIT    = 3'd0;
  localparam pc_t UA_LOAD    = 3'd1;
  localparam pc_t UA_STEP    = 3'd2;
  localparam pc_t UA_LOOP    = 3'd3;
  localparam pc_t UA_STORE   = 3'd4;
  localparam pc_t UA_GUARD   = 3'd5;
  localparam pc_t UA_OUT     = 3'd6;
  localparam pc_t UA_RESTART = 3'd7;

  // Status from datapath to sequencer
  typedef struct packed {
    logic loop_go;
    logic op_special;
    logic out_busy;
  } dp_status_t;

  // Control from sequencer to datapath
  typedef struct packed {
    dp_op_t op;
    logic   restart;
  } dp_ctrl_t;

  // Microcode ROM
  function automatic ucode_t ucode_rom(input pc_t addr);
    ucode_t w;
    unique case (addr)
      UA_WAIT:    w = '{op: DP_CAPTURE, restart: 1'b0, cond: COND_NO_ITEM,
                        target: UA_WAIT, need_out: 1'b0};
      UA_LOAD:    w = '{op: DP_LOAD, restart: 1'b0, cond: COND_SPECIAL,
                        target: UA_RESTART, need_out: 1'b0};
      UA_STEP:    w = '{op: DP_STEP, restart: 1'b0, cond: COND_NONE,
                        target: UA_WAIT, need_out: 1'b0};
      UA_LOOP:    w = '{op: DP_LOOP, restart: 1'b0, cond: COND_LOOP,
                        target: UA_LOOP, need_out: 1'b0};
      UA_STORE:   w = '{op: DP_STORE, restart: 1'b0, cond: COND_NONE,
                        target: UA_WAIT, need_out: 1'b0};
      UA_GUARD:   w = '{op: DP_GUARD, restart: 1'b0, cond: COND_NONE,
                        target: UA_WAIT, need_out: 1'b0};
      UA_OUT:     w = '{op: DP_OUTPUT, restart: 1'b0, cond: COND_ALWAYS,
                        target: UA_WAIT, need_out: 1'b1};
      UA_RESTART: w = '{op: DP_NOP, restart: 1'b1, cond: COND_ALWAYS,
                        target: UA_OUT, need_out: 1'b0};
      default:    w = '{op: DP_NOP, restart: 1'b0, cond: COND_ALWAYS,
                        target: UA_WAIT, need_out: 1'b0};
    endcase
    return w;
  endfunction

endpackage

@@ design/ptms_seq.sv @@
// Microcode sequencer: step counter, control ROM and jump logic.
// Depends on ptms_pkg for the ROM and the control and status structs.
module ptms_seq (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  ptms_pkg::dp_status_t  status,
  output ptms_pkg::dp_ctrl_t    ctrl,
  output logic                  in_stall
);

  ptms_pkg::pc_t    pc;
  ptms_pkg::pc_t    pc_next;
  ptms_pkg::ucode_t word;
  logic             hold;
  logic             take;

  assign word     = ptms_pkg::ucode_rom(pc);
  assign in_stall = (word.op != ptms_pkg::DP_CAPTURE);

  // Hold the step while the output register is still full
  assign hold = word.need_out && status.out_busy;

  // Gate the datapath op
  always_comb begin
    ctrl.restart = word.restart;
    if (hold || (word.op == ptms_pkg::DP_CAPTURE && !in_valid)) begin
      ctrl.op = ptms_pkg::DP_NOP;
    end else begin
      ctrl.op = word.op;
    end
  end

  // Pick the next step
  always_comb begin
    unique case (word.cond)
      ptms_pkg::COND_NONE:    take = 1'b0;
      ptms_pkg::COND_ALWAYS:  take = 1'b1;
      ptms_pkg::COND_NO_ITEM: take = !in_valid;
      ptms_pkg::COND_SPECIAL: take = status.op_special;
      ptms_pkg::COND_LOOP:    take = status.loop_go;
      default:                take = 1'b0;
    endcase
    if (hold) begin
      pc_next = pc;
    end else if (take) begin
      pc_next = word.target;
    end else begin
      pc_next = pc + ptms_pkg::pc_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= ptms_pkg::UA_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

@@ design/ptms_datapath.sv @@
// Datapath: configuration registers, channel matches, error accumulator,
// catch-up working registers and the output register. Uses ptms_pkg.
module ptms_datapath #(
  parameter int MAX_CATCHUP   = ptms_pkg::MAX_CATCHUP_DEF,
  parameter int COUNTER_WIDTH = ptms_pkg::COUNTER_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [31:0]           cfg_data,
  input  ptms_pkg::in_word_t    in_word,
  input  ptms_pkg::dp_ctrl_t    ctrl,
  output ptms_pkg::dp_status_t  status,
  input  logic                  out_stall,
  output logic                  out_valid,
  output ptms_pkg::out_word_t   out_word
);

  localparam int CW = COUNTER_WIDTH;
  localparam int EW = ptms_pkg::ERR_W;
  localparam int NW = ptms_pkg::CNT_W;
  localparam logic [NW-1:0] MAX_C = NW'(MAX_CATCHUP);

  // Configuration
  logic [31:0] hard_step;
  logic [15:0] hard_rem;
  logic [15:0] ticks_ps;
  logic [31:0] stat_step;
  logic [15:0] guard_ticks;

  // Channel state
  logic [CW-1:0] hard_match;
  logic [CW-1:0] stat_match;
  logic [EW-1:0] step_error;

  // Working registers
  logic [1:0]    op_r;
  logic [CW-1:0] now_r;
  logic [CW-1:0] match;
  logic [NW-1:0] count;
  logic          past_f;
  logic          guard_f;

  logic          is_hard;
  logic [CW-1:0] diff;
  logic          past;
  logic [EW-1:0] err_sum;
  logic          err_corr;
  logic [EW-1:0] err_next;
  logic [CW-1:0] step_add;
  logic [CW-1:0] match_next;
  logic [CW-1:0] lead;
  logic          do_step;

  assign is_hard = (op_r == ptms_pkg::OP_HARD);

  // Snapshot strictly past the match, signed difference
  assign diff = now_r - match;
  assign past = (diff != '0) && !diff[CW-1];

  // One period: error compare and subtract, then match advance
  assign err_sum  = step_error + EW'(hard_rem);
  assign err_corr = (err_sum >= EW'(ticks_ps));
  assign err_next = err_corr ? (err_sum - EW'(ticks_ps)) : err_sum;
  assign step_add = is_hard ? hard_step[CW-1:0] : stat_step[CW-1:0];
  assign match_next = match + step_add + CW'(is_hard && err_corr);

  assign lead = match - now_r;

  assign status.loop_go    = past && (count < MAX_C);
  assign status.op_special = op_r[1];
  assign status.out_busy   = out_valid && out_stall;

  assign do_step = (ctrl.op == ptms_pkg::DP_STEP) ||
                   (ctrl.op == ptms_pkg::DP_LOOP && status.loop_go);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      hard_step   <= ptms_pkg::RST_HARD_STEP;
      hard_rem    <= ptms_pkg::RST_HARD_REMAINDER;
      ticks_ps    <= ptms_pkg::RST_TICKS_PER_SEC;
      stat_step   <= ptms_pkg::RST_STAT_STEP;
      guard_ticks <= ptms_pkg::RST_GUARD_TICKS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ptms_pkg::REG_HARD_STEP:      hard_step   <= cfg_data;
        ptms_pkg::REG_HARD_REMAINDER: hard_rem    <= cfg_data[15:0];
        ptms_pkg::REG_TICKS_PER_SEC:  ticks_ps    <= cfg_data[15:0];
        ptms_pkg::REG_STAT_STEP:      stat_step   <= cfg_data;
        ptms_pkg::REG_GUARD_TICKS:    guard_ticks <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Channel state: write back matches, advance the error
  always_ff @(posedge clk) begin
    if (rst) begin
      hard_match <= '0;
      stat_match <= '0;
      step_error <= '0;
    end else begin
      if (do_step && is_hard) begin
        step_error <= err_next;
      end
      if (ctrl.op == ptms_pkg::DP_STORE) begin
        if (is_hard) begin
          hard_match <= match;
        end else begin
          stat_match <= match;
        end
      end
      if (ctrl.restart && op_r == ptms_pkg::OP_RESTART) begin
        stat_match <= now_r + stat_step[CW-1:0];
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (ctrl.op == ptms_pkg::DP_CAPTURE) begin
      op_r  <= in_word.operation;
      now_r <= in_word.counter_now[CW-1:0];
    end
    if (ctrl.op == ptms_pkg::DP_LOAD) begin
      match   <= is_hard ? hard_match : stat_match;
      count   <= '0;
      past_f  <= 1'b0;
      guard_f <= 1'b0;
    end
    if (do_step) begin
      match <= match_next;
      count <= count + NW'(1);
    end
    if (ctrl.op == ptms_pkg::DP_STORE) begin
      past_f  <= past;
      guard_f <= (lead < CW'(guard_ticks));
    end
    if (ctrl.op == ptms_pkg::DP_GUARD && guard_f) begin
      match <= match + CW'(guard_ticks);
    end
    if (ctrl.restart) begin
      match <= (op_r == ptms_pkg::OP_RESTART) ? (now_r + stat_step[CW-1:0]) : '0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.op == ptms_pkg::DP_OUTPUT) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == ptms_pkg::DP_OUTPUT) begin
      out_word.next_match      <= 32'(match);
      out_word.tick_count      <= count;
      out_word.catchup_overrun <= past_f;
      out_word.guard_applied   <= guard_f;
    end
  end

endmodule

@@ design/periodic_tick_match_scheduler_unit.sv @@
// Periodic tick match scheduler: a microcoded sequencer runs a catch-up loop
// that issues one period per cycle. An event item that issues N periods
// (1 to MAX_CATCHUP) passes the load, step, loop, store and guard steps
// before its result word is loaded into the output register at the output
// step, and the block accepts again in the cycle after; a restart or unused
// operation passes the load, restart and output steps. A result waiting in
// the output register holds the sequencer only at its output step.
// Configuration writes are always taken (cfg_ready is high) and must be made
// while no item is in flight.
module periodic_tick_match_scheduler_unit #(
  parameter int MAX_CATCHUP   = ptms_pkg::MAX_CATCHUP_DEF,
  parameter int COUNTER_WIDTH = ptms_pkg::COUNTER_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  ptms_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output ptms_pkg::out_word_t out_word
);

  ptms_pkg::dp_ctrl_t   ctrl;
  ptms_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  ptms_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .status   (status),
    .ctrl     (ctrl),
    .in_stall (in_stall)
  );

  ptms_datapath #(
    .MAX_CATCHUP   (MAX_CATCHUP),
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_word   (in_word),
    .ctrl      (ctrl),
    .status    (status),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

@@ design/ptms_checker.sv @@
// Port-level checker for the periodic tick match scheduler, bound to the top.
// Depends on ptms_pkg for the payload structs.
module ptms_checker #(
  parameter int MAX_CATCHUP = ptms_pkg::MAX_CATCHUP_DEF
) (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input ptms_pkg::out_word_t out_word
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  // One item at a time: stall right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second word accepted while busy");

  // Overrun only at the cap
  a_overrun_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.catchup_overrun |->
      out_word.tick_count == ptms_pkg::CNT_W'(MAX_CATCHUP))
    else $error("overrun below the catch-up cap");

  // Restart results carry no flags
  a_zero_ticks: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.tick_count == '0 |->
      !out_word.catchup_overrun && !out_word.guard_applied)
    else $error("flags set on a result with no periods");

endmodule

bind periodic_tick_match_scheduler_unit ptms_checker #(
  .MAX_CATCHUP (MAX_CATCHUP)
) u_ptms_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

@@ bench/match_check_pkg.sv @@
// Result checker for the periodic tick match scheduler bench.
// Holds a predictor of both timer channels and the queue of match words due.
// Depends on ptms_pkg for the payload structs, register indexes and op codes.
package match_check_pkg;
  import ptms_pkg::*;

  localparam int CATCHUP_CAP = MAX_CATCHUP_DEF;

  class match_predictor;
    // Register copies
    logic [31:0] hard_step;
    logic [15:0] hard_rem;
    logic [15:0] ticks_rate;
    logic [31:0] stat_step;
    logic [15:0] guard;

    // Channel state
    logic [31:0] hard_match;
    logic [31:0] stat_match;
    logic [ERR_W-1:0] step_error;

    out_word_t due_matches[$];
    int mismatches;
    int results_seen;

    function new();
      hard_step    = RST_HARD_STEP;
      hard_rem     = RST_HARD_REMAINDER;
      ticks_rate   = RST_TICKS_PER_SEC;
      stat_step    = RST_STAT_STEP;
      guard        = RST_GUARD_TICKS;
      hard_match   = '0;
      stat_match   = '0;
      step_error   = '0;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function void apply_reg(logic [2:0] index, logic [31:0] data);
      case (index)
        REG_HARD_STEP:      hard_step  = data;
        REG_HARD_REMAINDER: hard_rem   = data[15:0];
        REG_TICKS_PER_SEC:  ticks_rate = data[15:0];
        REG_STAT_STEP:      stat_step  = data;
        REG_GUARD_TICKS:    guard      = data[15:0];
        default: ;
      endcase
    endfunction

    // Issue periods until the snapshot is no longer past the match, up to the cap
    function out_word_t advance_channel(bit hard, logic [31:0] now);
      out_word_t r;
      logic [31:0] m;
      logic [31:0] gap;
      logic [31:0] lead;
      int unsigned periods;
      bit past;
      m = hard ? hard_match : stat_match;
      periods = 0;
      do begin
        if (hard) begin
          m = m + hard_step;
          step_error = step_error + {1'b0, hard_rem};
          // one compare and subtract per period, extra count on carry
          if (step_error >= {1'b0, ticks_rate}) begin
            step_error = step_error - {1'b0, ticks_rate};
            m = m + 32'd1;
          end
        end else begin
          m = m + stat_step;
        end
        periods++;
        gap = now - m;
        past = (gap != 32'd0) && !gap[31];
      end while (past && periods < CATCHUP_CAP);
      if (hard) begin
        hard_match = m;
      end else begin
        stat_match = m;
      end
      // push the handed-out match later if it leads by too little
      lead = m - now;
      r.guard_applied   = lead < {16'd0, guard};
      r.next_match      = r.guard_applied ? m + {16'd0, guard} : m;
      r.tick_count      = CNT_W'(periods);
      r.catchup_overrun = past;
      return r;
    endfunction

    // Note an accepted event word and queue the match word it causes
    function void note_event_word(in_word_t w);
      out_word_t r;
      r = '0;
      case (w.operation)
        OP_HARD:    r = advance_channel(1'b1, w.counter_now);
        OP_STAT:    r = advance_channel(1'b0, w.counter_now);
        OP_RESTART: begin
          stat_match   = w.counter_now + stat_step;
          r.next_match = stat_match;
        end
        default: ;  // unused code: zero word, no state change
      endcase
      due_matches.push_back(r);
    endfunction

    // Compare an accepted result word with the oldest one due
    function void check_match_word(out_word_t got);
      out_word_t want;
      results_seen++;
      if (due_matches.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: none due, got match %h ticks %0d overrun %b guard %b",
                   results_seen, got.next_match, got.tick_count,
                   got.catchup_overrun, got.guard_applied);
      end else begin
        want = due_matches.pop_front();
        if (got.next_match !== want.next_match || got.tick_count !== want.tick_count ||
            got.catchup_overrun !== want.catchup_overrun ||
            got.guard_applied !== want.guard_applied) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"result %0d: expected match %h ticks %0d overrun %b guard %b,",
                      " got match %h ticks %0d overrun %b guard %b"},
                     results_seen, want.next_match, want.tick_count,
                     want.catchup_overrun, want.guard_applied, got.next_match,
                     got.tick_count, got.catchup_overrun, got.guard_applied);
        end
      end
    endfunction
  endclass

endpackage

@@ bench/periodic_tick_match_scheduler_unit_test.sv @@
// Top-level bench for periodic_tick_match_scheduler_unit.
// Drives event words and register writes, checks every match word against
// the predictor in match_check_pkg; depends on ptms_pkg and match_check_pkg.
module periodic_tick_match_scheduler_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ptms_pkg::*;
  import match_check_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int QUIET_LIMIT   = 5000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 80;
  localparam int PHASE_ITEMS   = 142;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  in_word_t    in_word;
  logic        out_valid;
  logic        out_stall;
  out_word_t   out_word;

  int send_idle = 21;
  int recv_idle = 78;
  logic pressure_req = 1'b0;
  logic hold_off = 1'b0;
  int quiet_cycles = 0;

  match_predictor sb = new();

  periodic_tick_match_scheduler_unit DUT (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word(out_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stall the result side at random, or hold it off entirely
  always @(negedge clk) begin
    out_stall <= hold_off || ($urandom_range(99) < recv_idle);
  end

  // Hold off the receiver for a long stretch once asked
  initial begin
    wait (pressure_req);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  // Check results, note accepted words and register writes, watch for hangs
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_match_word(out_word);
    if (!rst && in_valid && !in_stall) sb.note_event_word(in_word);
    if (!rst && cfg_valid && cfg_ready) sb.apply_reg(cfg_index, cfg_data);
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("periodic_tick_match_scheduler_unit_test NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one event word after a random gap, return at the falling edge after acceptance
  task automatic offer_event(input logic [1:0] op, input logic [31:0] now);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= '{operation: op, counter_now: now};
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic put_reg(input logic [2:0] index, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic write_config(input logic [31:0] hs, input logic [31:0] rem,
                              input logic [31:0] tps, input logic [31:0] ss,
                              input logic [31:0] g);
    put_reg(REG_HARD_STEP, hs);
    put_reg(REG_HARD_REMAINDER, rem);
    put_reg(REG_TICKS_PER_SEC, tps);
    put_reg(REG_STAT_STEP, ss);
    put_reg(REG_GUARD_TICKS, g);
    cfg_valid <= 1'b0;
  endtask

  // Drop valid and wait until every due match word has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.due_matches.size() != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] random_step();
    case ($urandom_range(3))
      0: return $urandom_range(1, 64);
      1: return $urandom_range(1, 200000);
      2: return $urandom | 32'd1;
      default: return RST_HARD_STEP;
    endcase
  endfunction

  initial begin
    logic [31:0] base;
    logic [31:0] stride;
    logic [31:0] span;
    logic [31:0] now;
    logic [31:0] tps;
    logic [31:0] rem;
    logic [31:0] g;
    logic [1:0]  op;
    int r;
    int kind;
    int phase;
    int n;

    rst       = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_word   = '0;
    out_stall = 1'b0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset setting: restart, guard, catch-up cap, counter wrap, unused code
    offer_event(OP_RESTART, 32'h0000_0000);
    offer_event(OP_STAT, 32'h0000_0000);
    offer_event(OP_STAT, sb.stat_match + 32'd57600 * 3 + 32'd10);
    offer_event(OP_STAT, sb.stat_match + 32'd57600 - 32'd100);
    offer_event(OP_HARD, 32'hFFFF_FFFF);
    offer_event(OP_HARD, sb.hard_match + 32'h7FFF_FFFF);
    offer_event(OP_HARD, 32'h8000_0000);
    offer_event(OP_UNUSED, 32'hFFFF_FFFF);
    offer_event(OP_RESTART, 32'hFFFF_FFFF);

    // Ordinary error correction, unit stat step, widest guard
    wait_drained();
    write_config(32'd1000, 32'd37, 32'd100, 32'd1, 32'd65535);
    offer_event(OP_HARD, sb.hard_match + 32'd5000);
    offer_event(OP_HARD, sb.hard_match + 32'd100000);
    offer_event(OP_STAT, sb.stat_match + 32'd10);
    offer_event(OP_STAT, sb.stat_match + 32'd1000);
    offer_event(OP_UNUSED, 32'h0000_0000);

    // Zero tick rate with a step that wraps back onto the match
    wait_drained();
    write_config(32'hFFFF_FFFF, 32'd65534, 32'd0, 32'hFFFF_FFFF, 32'd0);
    offer_event(OP_HARD, sb.hard_match);
    offer_event(OP_HARD, sb.hard_match + 32'd5);
    offer_event(OP_STAT, sb.stat_match - 32'd3);
    offer_event(OP_RESTART, 32'h0000_0000);

    // Remainder above the tick rate: error grows and wraps
    wait_drained();
    write_config(32'd36864, 32'd60000, 32'd7, 32'd57600, 32'd500);
    offer_event(OP_HARD, sb.hard_match + 32'd36870 * 20);
    offer_event(OP_HARD, sb.hard_match + 32'd36870 * 3 - 32'd200);

    // Random phases: two per idle pattern, long receiver hold-off in phase 4
    for (phase = 0; phase < 6; phase++) begin
      wait_drained();
      case (phase)
        0: write_config(RST_HARD_STEP, RST_HARD_REMAINDER, RST_TICKS_PER_SEC,
                        RST_STAT_STEP, RST_GUARD_TICKS);
        1: write_config(32'd1, 32'd0, 32'd1, 32'd1, 32'd0);
        2: write_config(32'hFFFF_FFFF, 32'd65534, 32'd65535, 32'hFFFF_FFFF, 32'd65535);
        default: begin
          tps = $urandom_range(1, 65535);
          rem = $urandom_range(1) ? $urandom_range(0, tps - 1) : $urandom_range(0, 65534);
          g   = $urandom_range(1) ? $urandom_range(0, 65535) : $urandom_range(0, 1000);
          write_config(random_step(), rem, tps, random_step(), g);
        end
      endcase
      case (phase / 2)
        0: begin
          send_idle = 21;
          recv_idle = 78;
        end
        1: begin
          send_idle = 78;
          recv_idle = 21;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      if (phase == 4) pressure_req = 1'b1;

      for (n = 0; n < PHASE_ITEMS; n++) begin
        r  = $urandom_range(99);
        op = (r < 45) ? OP_HARD : (r < 80) ? OP_STAT : (r < 92) ? OP_RESTART : OP_UNUSED;
        base   = (op == OP_HARD) ? sb.hard_match : sb.stat_match;
        stride = (op == OP_HARD) ? sb.hard_step : sb.stat_step;
        span   = {16'd0, sb.guard} + 32'd100;
        kind   = $urandom_range(9);
        // Place the snapshot relative to the channel's match
        case (kind)
          0, 1, 2, 3, 4:
            now = base + stride * $urandom_range(0, 8) + $urandom_range(0, 2 * span) - span;
          5, 6:    now = base + stride * $urandom_range(60, 70) + $urandom_range(0, 15);
          7:       now = $urandom;
          8:       now = base + 32'h7FFF_FFFE + $urandom_range(0, 2);
          default: now = base - $urandom_range(0, 4096);
        endcase
        offer_event(op, now);
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.due_matches.size() == 0) begin
      $display("periodic_tick_match_scheduler_unit_test OK");
    end else begin
      $display("periodic_tick_match_scheduler_unit_test NOT OK");
    end
    $finish;
  end

endmodule
